### rtl/length_prefixed_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer assertion macros
// Concurrent assertion wrappers on clock, with reset as the disable term.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LPFD_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpfd assertion failed");
`define LPFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpfd assertion failed");
`else
`define LPFD_ASSERT_IMPLIES(label, ante, cons)
`define LPFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer package
// Shared types, register codes and protocol constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfd_pkg;

   localparam logic [31:0] HELLO_MAGIC = 32'h544e4b50;
   localparam logic [7:0]  TYPE_PING   = 8'h01;
   localparam logic [7:0]  TYPE_CTRL   = 8'h10;
   localparam logic [7:0]  CH_LF       = 8'h0a;
   localparam logic [7:0]  CH_CR       = 8'h0d;
   localparam logic [2:0]  LAST_INDEX  = 3'd7;

   localparam int LEN_W  = 19;
   localparam int KEEP_W = 16;

   localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 19'd262144;
   localparam logic [KEEP_W-1:0] KEEP_LIMIT_RESET  = 16'd8192;
   localparam logic [7:0]        PING_LIMIT_RESET  = 8'd16;
   localparam logic [7:0]        VERSION_RESET     = 8'd1;

   typedef enum logic [1:0] {
      CSR_MAX_PAYLOAD    = 2'd0,
      CSR_KEEP_LIMIT     = 2'd1,
      CSR_PING_LIMIT     = 2'd2,
      CSR_EXPECT_VERSION = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_HELLO   = 4'b0001,
      PH_HEADER  = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_FAILED  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [LEN_W-1:0]  max_payload;
      logic [KEEP_W-1:0] keep_limit;
      logic [7:0]        ping_limit;
      logic [7:0]        expect_version;
   } cfg_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } beat_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] frame_type;
      logic       frame_done;
      logic       frame_ok;
      logic       hello_done;
      logic       protocol_error;
      logic       failed;
   } result_type;

endpackage

`default_nettype wire

### rtl/lpfd_csr.sv
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Holds the length limits and the expected hello version.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_csr
   import lpfd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_index,
   input  wire logic [LEN_W-1:0]  csr_write_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_PAYLOAD:    cfg_in.max_payload    = csr_write_data;
            CSR_KEEP_LIMIT:     cfg_in.keep_limit     = csr_write_data[KEEP_W-1:0];
            CSR_PING_LIMIT:     cfg_in.ping_limit     = csr_write_data[7:0];
            CSR_EXPECT_VERSION: cfg_in.expect_version = csr_write_data[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_payload    <= MAX_PAYLOAD_RESET;
         cfg_ff.keep_limit     <= KEEP_LIMIT_RESET;
         cfg_ff.ping_limit     <= PING_LIMIT_RESET;
         cfg_ff.expect_version <= VERSION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/lpfd_in_stage.sv
// ----------------------------------------------------------------------------
// Deframer input register
// Captures one request beat and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_in_stage
   import lpfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_type,
   input  wire logic [7:0] req_rx_byte,
   output logic            beat_valid,
   output beat_type        beat,
   input  wire logic       beat_take
);

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;
   logic     req_fire;

   assign req_ready = !valid_ff || beat_take;
   assign req_fire  = req_valid && req_ready;
   assign valid_in  = req_fire || (valid_ff && !beat_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         beat_ff.req_type <= req_type;
         beat_ff.rx_byte  <= req_rx_byte;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

`default_nettype wire

### rtl/lpfd_parser.sv
// ----------------------------------------------------------------------------
// Deframer stream parser
// Hello check, header decode, payload count and frame verdict per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_parser
   import lpfd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire beat_type beat,
   input  wire logic     fire,
   output result_type    result,
   output phase_type     phase
);

   phase_type        phase_ff, phase_in;
   logic [2:0]       idx_ff, idx_in;
   logic [7:0]       type_ff, type_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             over_ff, over_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic             handled_ff, handled_in;
   logic             lbs_ff, lbs_in;
   logic             bad_ff, bad_in;

   function automatic logic [7:0] magic_byte(input logic [1:0] i);
      magic_byte = HELLO_MAGIC[{i, 3'b000} +: 8];
   endfunction

   function automatic logic verdict(input logic             handled,
                                    input logic [7:0]       ftype,
                                    input logic [LEN_W-1:0] len,
                                    input logic             lbs,
                                    input logic [7:0]       ping_limit);
      if (!handled) begin
         verdict = 1'b0;
      end else if (ftype == TYPE_PING) begin
         verdict = len <= {{(LEN_W-8){1'b0}}, ping_limit};
      end else begin
         verdict = (len != '0) && !lbs;
      end
   endfunction

   always_comb begin
      logic [7:0] b;
      logic       over_now;
      logic       hello_chk;
      b          = beat.rx_byte;
      over_now   = over_ff || (b != 8'h00);
      hello_chk  = 1'b0;
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      type_in    = type_ff;
      len_in     = len_ff;
      over_in    = over_ff;
      left_in    = left_ff;
      handled_in = handled_ff;
      lbs_in     = lbs_ff;
      bad_in     = bad_ff;
      result     = '0;

      if (beat.req_type) begin
         phase_in   = PH_HELLO;
         idx_in     = 3'd0;
         type_in    = 8'h00;
         len_in     = '0;
         over_in    = 1'b0;
         left_in    = '0;
         handled_in = 1'b0;
         lbs_in     = 1'b0;
         bad_in     = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_HELLO: begin
               if (!idx_ff[2]) begin
                  hello_chk = b != magic_byte(idx_ff[1:0]);
               end else if (idx_ff == 3'd4) begin
                  hello_chk = b != cfg.expect_version;
               end
               if (idx_ff == LAST_INDEX) begin
                  if (bad_ff) begin
                     result.protocol_error = 1'b1;
                     phase_in              = PH_FAILED;
                  end else begin
                     result.hello_done = 1'b1;
                     phase_in          = PH_HEADER;
                  end
                  idx_in = 3'd0;
                  bad_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 3'd1;
                  bad_in = bad_ff || hello_chk;
               end
            end
            PH_HEADER: begin
               idx_in = idx_ff + 3'd1;
               case (idx_ff) inside
                  3'd0: begin
                     type_in = b;
                     len_in  = '0;
                     over_in = 1'b0;
                     bad_in  = 1'b0;
                     lbs_in  = 1'b0;
                  end
                  3'd2, 3'd3: bad_in = bad_ff || (b != 8'h00);
                  3'd4: len_in[7:0]   = b;
                  3'd5: len_in[15:8]  = b;
                  3'd6: begin
                     len_in[18:16] = b[2:0];
                     over_in       = over_ff || (b[7:3] != 5'd0);
                  end
                  3'd7: begin
                     idx_in = 3'd0;
                     bad_in = 1'b0;
                     if (bad_ff || over_now || (len_ff > cfg.max_payload)) begin
                        result.protocol_error = 1'b1;
                        phase_in              = PH_FAILED;
                     end else begin
                        handled_in = (len_ff <= {{(LEN_W-KEEP_W){1'b0}}, cfg.keep_limit})
                                     && ((type_ff == TYPE_PING) || (type_ff == TYPE_CTRL));
                        left_in    = len_ff;
                        if (len_ff == '0) begin
                           result.frame_done = 1'b1;
                           result.frame_ok   = verdict(handled_in, type_ff, len_ff, lbs_ff,
                                                       cfg.ping_limit);
                        end else begin
                           phase_in = PH_PAYLOAD;
                        end
                     end
                  end
                  default: idx_in = idx_ff + 3'd1;
               endcase
            end
            PH_PAYLOAD: begin
               if (handled_ff) begin
                  result.payload_valid = 1'b1;
                  result.payload_byte  = b;
                  lbs_in               = lbs_ff || (b == CH_LF) || (b == CH_CR);
               end
               left_in = left_ff - LEN_W'(1);
               if (left_in == '0) begin
                  result.frame_done = 1'b1;
                  result.frame_ok   = verdict(handled_ff, type_ff, len_ff, lbs_in,
                                              cfg.ping_limit);
                  phase_in          = PH_HEADER;
                  idx_in            = 3'd0;
               end
            end
            PH_FAILED: phase_in = PH_FAILED;
            default:   phase_in = PH_FAILED;
         endcase
         result.frame_type = type_in;
         result.failed     = phase_in == PH_FAILED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HELLO;
         idx_ff     <= 3'd0;
         type_ff    <= 8'h00;
         len_ff     <= '0;
         over_ff    <= 1'b0;
         left_ff    <= '0;
         handled_ff <= 1'b0;
         lbs_ff     <= 1'b0;
         bad_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         type_ff    <= type_in;
         len_ff     <= len_in;
         over_ff    <= over_in;
         left_ff    <= left_in;
         handled_ff <= handled_in;
         lbs_ff     <= lbs_in;
         bad_ff     <= bad_in;
      end
   end

   assign phase = phase_ff;

endmodule

`default_nettype wire

### rtl/lpfd_out_stage.sv
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_out_stage
   import lpfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load_valid,
   output logic            load_ready,
   input  wire result_type load_result,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output result_type      rsp_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   logic       load;

   assign load_ready = !valid_ff || rsp_ready;
   assign load       = load_valid && load_ready;
   assign valid_in   = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

### rtl/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer
// Checks the hello acknowledgement, parses 8-byte frame headers and streams
// payload bytes with a verdict on the last byte of every frame.
//
//   Channel  Ports       Direction  Beat
//   req      req_*       in         one stream byte or a restart
//   rsp      rsp_*       out        one result per request beat
//   csr      csr_*       in         register write, no handshake
//
// One request beat is taken per cycle while rsp_ready is high; its result is
// offered behind the input register and the result register.
// Throughput is one beat per cycle with rsp_ready high, one parser pass per byte.
// Reset is synchronous and returns the parser to awaiting hello with the
// registers at their defaults.
// With rsp_ready low a full result register holds, and the input register
// still takes one more beat if it is empty before req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "length_prefixed_frame_deframer_defines.svh"

module length_prefixed_frame_deframer
   import lpfd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [1:0]       csr_index,
   input  wire logic [LEN_W-1:0] csr_write_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_type,
   input  wire logic [7:0]       req_rx_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_payload_valid,
   output logic [7:0]            rsp_payload_byte,
   output logic [7:0]            rsp_frame_type,
   output logic                  rsp_frame_done,
   output logic                  rsp_frame_ok,
   output logic                  rsp_hello_done,
   output logic                  rsp_protocol_error,
   output logic                  rsp_failed
);

   cfg_type    cfg;
   beat_type   s1_beat;
   logic       s1_valid;
   logic       s1_take;
   logic       out_ready;
   result_type parse_result;
   result_type rsp_result;
   phase_type  parse_phase;

   lpfd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lpfd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_rx_byte (req_rx_byte),
      .beat_valid  (s1_valid),
      .beat        (s1_beat),
      .beat_take   (s1_take)
   );

   assign s1_take = s1_valid && out_ready;

   lpfd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .beat   (s1_beat),
      .fire   (s1_take),
      .result (parse_result),
      .phase  (parse_phase)
   );

   lpfd_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (s1_valid),
      .load_ready  (out_ready),
      .load_result (parse_result),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_result  (rsp_result)
   );

   assign rsp_payload_valid  = rsp_result.payload_valid;
   assign rsp_payload_byte   = rsp_result.payload_byte;
   assign rsp_frame_type     = rsp_result.frame_type;
   assign rsp_frame_done     = rsp_result.frame_done;
   assign rsp_frame_ok       = rsp_result.frame_ok;
   assign rsp_hello_done     = rsp_result.hello_done;
   assign rsp_protocol_error = rsp_result.protocol_error;
   assign rsp_failed         = rsp_result.failed;

   `LPFD_ASSERT_IMPLIES(a_ok_needs_done, rsp_valid && rsp_frame_ok, rsp_frame_done)
   `LPFD_ASSERT_IMPLIES(a_error_sets_failed, rsp_valid && rsp_protocol_error, rsp_failed)
   `LPFD_ASSERT_NEXT(a_restart_to_hello, s1_take && s1_beat.req_type, parse_phase == PH_HELLO)
   `LPFD_ASSERT_NEXT(a_failed_sticky, s1_take && !s1_beat.req_type && parse_phase == PH_FAILED,
                     parse_phase == PH_FAILED)

endmodule

`default_nettype wire
